>>> rtl/radix_digit_emitter_unit_defines.svh
// ----------------------------------------------------------------------------
// Radix digit emitter assertion macros
// Shared concurrent assertion forms for the radix digit emitter RTL.
// ----------------------------------------------------------------------------
// In simulation the macros expand to labeled concurrent assertions that
// report through $error. In synthesis they expand to nothing.
`ifndef RADIX_DIGIT_EMITTER_UNIT_DEFINES_SVH
`define RADIX_DIGIT_EMITTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RDE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RDE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define RDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// Radix digit emitter package
// Fixed widths, character codes and shared types of the radix digit emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

    // Symbol table register file: eight 64-bit registers, 64 bytes in all.
    localparam int NUM_REGS   = 8;
    localparam int REG_W      = 64;
    localparam int REG_SEL_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int TBL_ADDR_W = 6;
    localparam int SEEN_W     = 128;

    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] tbl_regs_t;

    // Status of the table checker as seen by the top level.
    typedef struct packed {
        logic busy;
        logic valid;
    } tbl_stat_t;

endpackage

`default_nettype wire

>>> rtl/radix_digit_emitter_unit.sv
// ----------------------------------------------------------------------------
// Radix digit emitter
// Converts a signed value to text in a radix defined by a symbol table.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                               | Beat
//  --------+---------------------------------------+-------------------------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | one table register write
//  in      | in_valid in_ready number               | one value to convert
//  out     | out_valid out_ready symbol last_symbol | one output character
//
// Each digit takes one pass of the bit-serial divider, each digit character
// a stack read and then a table lookup with output load, and a minus sign
// its own output load, so the divider loop sets most of an item's time.
// After a table register write the checker scans the table one byte per cycle,
// and in_ready stays low meanwhile.
// Reset clears the table, so the block starts with an invalid table.
// A stalled output beat holds the sequencer before its next output load only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix_digit_emitter_unit_defines.svh"

module radix_digit_emitter_unit #(
    parameter int VALUE_BITS  = 32,
    parameter int TABLE_BYTES = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write channel.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rde_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rde_pkg::REG_W-1:0]       cfg_data,
    // Input channel.
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [VALUE_BITS-1:0]    number,
    // Output channel.
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [7:0]                      symbol,
    output logic                                 last_symbol
);

    localparam int RW = $clog2(TABLE_BYTES + 1);
    localparam int DW = $clog2(TABLE_BYTES);
    localparam int AW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_LOOK = 3'd4;

    rde_pkg::tbl_regs_t           tbl_reg;
    rde_pkg::tbl_stat_t           chk_stat;
    logic [rde_pkg::TBL_ADDR_W-1:0] chk_addr;
    logic [rde_pkg::TBL_ADDR_W-1:0] tbl_addr;
    logic [7:0]                   tbl_data;
    logic [RW-1:0]                chk_radix;
    logic                         cfg_write;

    logic [2:0]            state_reg,  state_next;
    logic [CW-1:0]         cnt_reg,    cnt_next;
    logic [RW-1:0]         rad_reg,    rad_next;
    logic                  neg_reg,    neg_next;
    logic                  ovld_reg,   ovld_next;
    logic [7:0]            osym_reg,   osym_next;
    logic                  olast_reg,  olast_next;

    logic                  in_accept;
    logic                  out_free;
    logic [CW-1:0]         cnt_dec;
    logic [VALUE_BITS-1:0] num_u;
    logic [VALUE_BITS-1:0] mag;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [RW-1:0]         div_divisor;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [DW-1:0]         div_remainder;
    logic                  quo_zero;

    logic                  ram_we;
    logic                  ram_re;
    logic [DW-1:0]         ram_rdata;

    function automatic logic [7:0] tbl_byte(
        input rde_pkg::tbl_regs_t           t,
        input logic [rde_pkg::TBL_ADDR_W-1:0] a
    );
        logic [rde_pkg::REG_W-1:0] r;
        r = t[a[5:3]];
        return r[{a[2:0], 3'b000} +: 8];
    endfunction

    // ------------------------------------------------------------------
    // Symbol table registers. A write to an index beyond the table is
    // accepted and dropped. Every real write restarts the table check.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready &&
                       (cfg_index < rde_pkg::CFG_IDX_W'(rde_pkg::NUM_REGS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_reg <= '0;
        end
        else if (cfg_write)
        begin
            tbl_reg[cfg_index[rde_pkg::REG_SEL_W-1:0]] <= cfg_data;
        end
    end

    // The checker and the digit lookup share a single byte select on the table;
    // while the checker is busy it has the select, even during a conversion.
    assign tbl_addr = chk_stat.busy ? chk_addr : rde_pkg::TBL_ADDR_W'(ram_rdata);
    assign tbl_data = tbl_byte(tbl_reg, tbl_addr);

    rde_tbl_check #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg_write),
        .rd_byte (tbl_data),
        .rd_addr (chk_addr),
        .radix   (chk_radix),
        .stat    (chk_stat)
    );

    // ------------------------------------------------------------------
    // Digit generation: the divider peels off the least significant digit
    // of the magnitude each pass, and the digit goes onto the stack.
    // ------------------------------------------------------------------
    assign in_ready  = (state_reg == S_IDLE) && !chk_stat.busy;
    assign in_accept = in_valid && in_ready;

    // The most negative value negates to itself, which read unsigned is
    // exactly its magnitude.
    assign num_u = number;
    assign mag   = number[VALUE_BITS-1] ? (~num_u + VALUE_BITS'(1)) : num_u;

    assign quo_zero     = (div_quotient == '0);
    assign div_start    = (in_accept && chk_stat.valid) ||
                          (state_reg == S_DIV && div_done && !quo_zero);
    assign div_dividend = (state_reg == S_IDLE) ? mag : div_quotient;
    assign div_divisor  = (state_reg == S_IDLE) ? chk_radix : rad_reg;

    rde_divider #(
        .VALUE_BITS  (VALUE_BITS),
        .TABLE_BYTES (TABLE_BYTES)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // The stack is written at the digit count and read back from the top.
    assign ram_we  = (state_reg == S_DIV) && div_done;
    assign ram_re  = (state_reg == S_READ);
    assign cnt_dec = cnt_reg - CW'(1);

    rde_ram #(
        .WIDTH (DW),
        .DEPTH (VALUE_BITS)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (div_remainder),
        .re    (ram_re),
        .raddr (cnt_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer and output register. The output register is loaded
    // only when it is empty or its beat is taken in the same cycle.
    // ------------------------------------------------------------------
    assign out_free = !ovld_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rad_next   = rad_reg;
        neg_next   = neg_reg;
        ovld_next  = ovld_reg && !out_ready;
        osym_next  = osym_reg;
        olast_next = olast_reg;
        case (state_reg)
            S_IDLE:
            begin
                // With an invalid table the value is taken and yields nothing.
                if (in_accept && chk_stat.valid)
                begin
                    neg_next   = number[VALUE_BITS-1];
                    rad_next   = chk_radix;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    cnt_next = cnt_reg + CW'(1);
                    if (quo_zero)
                    begin
                        state_next = neg_reg ? S_SIGN : S_READ;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    ovld_next  = 1'b1;
                    osym_next  = rde_pkg::CHAR_MINUS;
                    olast_next = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cnt_next   = cnt_dec;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (out_free)
                begin
                    ovld_next  = 1'b1;
                    osym_next  = tbl_data;
                    olast_next = (cnt_reg == CW'(0));
                    state_next = (cnt_reg == CW'(0)) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rad_reg   <= '0;
            neg_reg   <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rad_reg   <= rad_next;
            neg_reg   <= neg_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        osym_reg  <= osym_next;
        olast_reg <= olast_next;
    end

    assign out_valid   = ovld_reg;
    assign symbol      = osym_reg;
    assign last_symbol = olast_reg;

    // The stack never takes more digits than the value has bits.
    `RDE_ASSERT_IMPL(a_stack_bound, clk, rst_n, (state_reg == S_DIV) && div_done, cnt_reg < CW'(VALUE_BITS), "digit stack overflow")
    // A value taken with a valid table always starts a division.
    `RDE_ASSERT_NEXT(a_start_div, clk, rst_n, in_accept && chk_stat.valid, (state_reg == S_DIV) && !in_ready, "division did not start")
    // Loading the bottom digit ends the run with the last mark set.
    `RDE_ASSERT_NEXT(a_last_ends_run, clk, rst_n, (state_reg == S_LOOK) && out_free && (cnt_reg == CW'(0)), (state_reg == S_IDLE) && ovld_reg && olast_reg, "run did not end on last symbol")

endmodule

`default_nettype wire

>>> rtl/rde_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/rde_tbl_check.sv
// ----------------------------------------------------------------------------
// Symbol table checker
// Scans the symbol table one byte per cycle to find the radix and validity.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_tbl_check #(
    parameter int TABLE_BYTES = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic [7:0]                           rd_byte,
    output logic      [rde_pkg::TBL_ADDR_W-1:0]       rd_addr,
    output logic      [$clog2(TABLE_BYTES+1)-1:0]     radix,
    output rde_pkg::tbl_stat_t                        stat
);

    localparam int RW = $clog2(TABLE_BYTES + 1);

    logic [RW-1:0]              idx_reg,   idx_next;
    logic [RW-1:0]              radix_reg, radix_next;
    logic [rde_pkg::SEEN_W-1:0] seen_reg,  seen_next;
    logic                       ok_reg,    ok_next;
    logic                       busy_reg,  busy_next;
    logic                       valid_reg, valid_next;
    logic                       alnum;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= rde_pkg::CHAR_LOWER_A && c <= rde_pkg::CHAR_LOWER_Z) ||
               (c >= rde_pkg::CHAR_UPPER_A && c <= rde_pkg::CHAR_UPPER_Z) ||
               (c >= rde_pkg::CHAR_DIGIT_0 && c <= rde_pkg::CHAR_DIGIT_9);
    endfunction

    assign alnum   = is_alnum(rd_byte);
    assign rd_addr = rde_pkg::TBL_ADDR_W'(idx_reg);

    always_comb
    begin
        idx_next   = idx_reg;
        radix_next = radix_reg;
        seen_next  = seen_reg;
        ok_next    = ok_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg;
        if (start)
        begin
            idx_next  = '0;
            seen_next = '0;
            ok_next   = 1'b1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (idx_reg == RW'(TABLE_BYTES) || rd_byte == 8'h00)
            begin
                // End of the table: its length is the radix.
                busy_next  = 1'b0;
                radix_next = idx_reg;
                valid_next = ok_reg && (idx_reg >= RW'(2));
            end
            else
            begin
                if (!alnum || seen_reg[rd_byte[6:0]])
                begin
                    ok_next = 1'b0;
                end
                if (alnum)
                begin
                    seen_next[rd_byte[6:0]] = 1'b1;
                end
                idx_next = idx_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            radix_reg <= '0;
            seen_reg  <= '0;
            ok_reg    <= 1'b0;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            radix_reg <= radix_next;
            seen_reg  <= seen_next;
            ok_reg    <= ok_next;
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    assign radix      = radix_reg;
    assign stat.busy  = busy_reg;
    assign stat.valid = valid_reg;

endmodule

`default_nettype wire

>>> rtl/rde_divider.sv
// ----------------------------------------------------------------------------
// Bit-serial radix divider
// Restoring division by the radix, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix_digit_emitter_unit_defines.svh"

module rde_divider #(
    parameter int VALUE_BITS  = 32,
    parameter int TABLE_BYTES = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [VALUE_BITS-1:0]            dividend,
    input  wire logic [$clog2(TABLE_BYTES+1)-1:0] divisor,
    output logic                                  done,
    output logic      [VALUE_BITS-1:0]            quotient,
    output logic      [$clog2(TABLE_BYTES)-1:0]   remainder
);

    localparam int RW   = $clog2(TABLE_BYTES + 1);
    localparam int DW   = $clog2(TABLE_BYTES);
    localparam int CNTW = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] quo_reg,  quo_next;
    logic [DW-1:0]         rem_reg,  rem_next;
    logic [RW-1:0]         div_reg,  div_next;
    logic [CNTW-1:0]       cnt_reg,  cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DW:0]           trial;
    logic [DW:0]           div_ext;
    logic [DW:0]           diff;
    logic                  ge;

    assign trial   = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign div_ext = (DW + 1)'(div_reg);
    assign ge      = trial >= div_ext;
    assign diff    = trial - div_ext;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // A trial below the divisor is below the table size, so it fits.
            rem_next = ge ? DW'(diff) : DW'(trial);
            quo_next = {quo_reg[VALUE_BITS-2:0], ge};
            cnt_next = cnt_reg + CNTW'(1);
            if (cnt_reg == CNTW'(VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `RDE_ASSERT_IMPL(a_rem_below_divisor, clk, rst_n, done_reg, (RW)'(rem_reg) < div_reg, "remainder not below divisor")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Radix digit emitter testbench
// Loads symbol tables of many radixes, good and broken, into the emitter,
// feeds it signed values with random gaps and output stalls, and checks every
// character beat against an in-bench prediction of the text form.
// ----------------------------------------------------------------------------
module testbench;

    localparam int VALUE_BITS    = 32;
    localparam int TABLE_BYTES   = 64;
    localparam int POOL_SIZE     = 62;
    localparam int RANDOM_ITEMS  = 320;
    // Worst item: 32 digits through the divider and 33 characters, with margin on top.
    localparam int SETTLE_CYCLES = 1300;
    localparam int CYCLE_LIMIT   = 10000000;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};

    // Ways in which a loaded table can be broken.
    typedef enum int {
        FLAW_NONE,
        FLAW_EMPTY,
        FLAW_SINGLE,
        FLAW_BAD_CHAR,
        FLAW_REPEAT,
        FLAW_UNTERMINATED,
        FLAW_SATURATED
    } table_flaw_t;

    // One expected character beat.
    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } char_beat_t;

    // Clock, reset and every block input start at a known value.
    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [rde_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [rde_pkg::REG_W-1:0]     cfg_data    = '0;
    logic                          in_valid    = 1'b0;
    logic                          in_ready;
    logic signed [VALUE_BITS-1:0]  number      = '0;
    logic                          out_valid;
    logic                          out_ready   = 1'b0;
    logic [7:0]                    symbol;
    logic                          last_symbol;

    // Bench copy of the table registers and the derived radix and validity.
    logic [rde_pkg::REG_W-1:0] table_regs [rde_pkg::NUM_REGS];
    int unsigned      table_radix;
    bit               table_ok;

    // Characters still owed by the block, oldest first.
    char_beat_t       expected_chars [$];

    // Staging area for the next table to load, and the pool of legal symbols.
    logic [7:0]       table_image [TABLE_BYTES];
    logic [7:0]       symbol_pool [POOL_SIZE];

    int               error_count      = 0;
    int               cycle_count      = 0;
    int               valid_items_sent = 0;
    int               stall_left       = 0;
    // When set, neither side idles: back-to-back beats on both channels.
    bit               steady_flow      = 1'b0;

    radix_digit_emitter_unit #(
        .VALUE_BITS  (VALUE_BITS),
        .TABLE_BYTES (TABLE_BYTES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .number      (number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .symbol      (symbol),
        .last_symbol (last_symbol)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Byte k of the table, byte 0 in the low bits of register 0.
    function automatic logic [7:0] table_byte(int k);
        return table_regs[k / 8][(k % 8) * 8 +: 8];
    endfunction

    function automatic bit is_symbol_char(logic [7:0] c);
        return (c >= rde_pkg::CHAR_LOWER_A && c <= rde_pkg::CHAR_LOWER_Z) ||
               (c >= rde_pkg::CHAR_UPPER_A && c <= rde_pkg::CHAR_UPPER_Z) ||
               (c >= rde_pkg::CHAR_DIGIT_0 && c <= rde_pkg::CHAR_DIGIT_9);
    endfunction

    // The radix is the position of the first zero byte. The table is usable
    // only with two or more symbols, all letters or digits, none repeated.
    function automatic void evaluate_table();
        int len;
        bit ok;
        len = 0;
        ok  = 1'b1;
        while (len < TABLE_BYTES && table_byte(len) != 8'h00)
            len++;
        for (int i = 0; i < len; i++)
        begin
            if (!is_symbol_char(table_byte(i)))
                ok = 1'b0;
            for (int j = i + 1; j < len; j++)
                if (table_byte(j) == table_byte(i))
                    ok = 1'b0;
        end
        if (len < 2)
            ok = 1'b0;
        table_radix = len;
        table_ok    = ok;
    endfunction

    // Queues the characters of one value: a minus sign for negative values,
    // then the digits of the magnitude, most significant first. The most
    // negative value has no positive twin, so its magnitude is taken unsigned.
    function automatic void predict_text(logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        logic [5:0]            digits [VALUE_BITS];
        int                    count;
        bit                    neg;
        char_beat_t            beat;
        if (!table_ok)
            return;
        neg   = v[VALUE_BITS-1];
        mag   = neg ? (~v + 1'b1) : v;
        count = 0;
        do
        begin
            digits[count] = 6'(mag % table_radix);
            mag           = mag / table_radix;
            count++;
        end
        while (mag != 0);
        if (neg)
        begin
            beat.symbol      = rde_pkg::CHAR_MINUS;
            beat.last_symbol = 1'b0;
            expected_chars.push_back(beat);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            beat.symbol      = table_byte(digits[i]);
            beat.last_symbol = (i == 0);
            expected_chars.push_back(beat);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sends one value. Valid is dropped during a gap and raised again at a
    // later falling edge, so it never changes twice within one time step.
    // After acceptance valid stays high; the next beat or release_input
    // replaces it at the following falling edge.
    task automatic send_number(logic [VALUE_BITS-1:0] v);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        number   <= v;
        do
            @(posedge clk);
        while (!in_ready);
        predict_text(v);
        if (table_ok)
            valid_items_sent++;
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // Items under a broken table leave no trace in the queue, so after the
    // last owed character the block gets its worst-case item time to finish.
    task automatic settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [rde_pkg::CFG_IDX_W-1:0] idx,
                                  logic [rde_pkg::REG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        // Indexes past the register file are dropped by the block.
        if (idx < rde_pkg::NUM_REGS)
        begin
            table_regs[idx] = data;
            evaluate_table();
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Writes the staged table into all eight registers once the block is
    // idle. A write to an unused index with random data lands somewhere in
    // the sequence most of the time.
    task automatic load_table();
        logic [rde_pkg::REG_W-1:0] word;
        int                        stray_at;
        release_input();
        settle();
        stray_at = $urandom_range(0, 2 * rde_pkg::NUM_REGS);
        for (int r = 0; r <= rde_pkg::NUM_REGS; r++)
        begin
            if (r == stray_at)
                write_register(rde_pkg::CFG_IDX_W'($urandom_range(rde_pkg::NUM_REGS,
                                   2 ** rde_pkg::CFG_IDX_W - 1)),
                               {$urandom, $urandom});
            if (r < rde_pkg::NUM_REGS)
            begin
                for (int b = 0; b < 8; b++)
                    word[b * 8 +: 8] = table_image[r * 8 + b];
                write_register(rde_pkg::CFG_IDX_W'(r), word);
            end
        end
    endtask

    // Digits, then capitals, then lower case.
    task automatic reset_symbol_pool();
        for (int i = 0; i < 10; i++)
            symbol_pool[i] = rde_pkg::CHAR_DIGIT_0 + 8'(i);
        for (int i = 0; i < 26; i++)
        begin
            symbol_pool[10 + i] = rde_pkg::CHAR_UPPER_A + 8'(i);
            symbol_pool[36 + i] = rde_pkg::CHAR_LOWER_A + 8'(i);
        end
    endtask

    // Stages a table of the given radix, in natural or shuffled symbol order,
    // with random bytes after the terminator, then breaks it as asked.
    task automatic build_table(int radix, bit scramble, table_flaw_t flaw);
        int         i;
        int         j;
        logic [7:0] t;
        reset_symbol_pool();
        if (scramble)
        begin
            for (int k = POOL_SIZE - 1; k > 0; k--)
            begin
                j              = $urandom_range(0, k);
                t              = symbol_pool[k];
                symbol_pool[k] = symbol_pool[j];
                symbol_pool[j] = t;
            end
        end
        for (int k = 0; k < TABLE_BYTES; k++)
            table_image[k] = (k < radix) ? symbol_pool[k] : 8'($urandom);
        if (radix < TABLE_BYTES)
            table_image[radix] = 8'h00;
        case (flaw)
            FLAW_EMPTY:
                for (int k = 0; k < TABLE_BYTES; k++)
                    table_image[k] = 8'h00;
            FLAW_SINGLE:
                table_image[1] = 8'h00;
            FLAW_BAD_CHAR:
            begin
                // Neighbors of the legal ranges and a few stray codes.
                i = $urandom_range(0, radix - 1);
                case ($urandom_range(0, 9))
                    0:       table_image[i] = rde_pkg::CHAR_DIGIT_0 - 8'd1;
                    1:       table_image[i] = rde_pkg::CHAR_DIGIT_9 + 8'd1;
                    2:       table_image[i] = rde_pkg::CHAR_UPPER_A - 8'd1;
                    3:       table_image[i] = rde_pkg::CHAR_UPPER_Z + 8'd1;
                    4:       table_image[i] = rde_pkg::CHAR_LOWER_A - 8'd1;
                    5:       table_image[i] = rde_pkg::CHAR_LOWER_Z + 8'd1;
                    6:       table_image[i] = rde_pkg::CHAR_MINUS;
                    7:       table_image[i] = 8'h80;
                    8:       table_image[i] = 8'hFF;
                    default: table_image[i] = 8'h01;
                endcase
            end
            FLAW_REPEAT:
            begin
                i              = $urandom_range(0, radix - 2);
                j              = $urandom_range(i + 1, radix - 1);
                table_image[j] = table_image[i];
            end
            FLAW_UNTERMINATED:
                // Only 62 distinct symbols exist, so a full table repeats.
                for (int k = radix; k < TABLE_BYTES; k++)
                    table_image[k] = symbol_pool[$urandom_range(0, radix - 1)];
            FLAW_SATURATED:
                for (int k = 0; k < TABLE_BYTES; k++)
                    table_image[k] = 8'hFF;
            default:
                ;
        endcase
    endtask

    // Pick a radix, leaning on both ends of the legal range.
    function automatic int pick_radix();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom_range(2, 4);
            2:       return $urandom_range(60, POOL_SIZE);
            default: return $urandom_range(2, POOL_SIZE);
        endcase
    endfunction

    // Full-range values, small ones, values of random bit length and the
    // edges of the signed range.
    function automatic logic [VALUE_BITS-1:0] random_number();
        logic [VALUE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 6))
                    0:       v = '0;
                    1:       v = 1;
                    2:       v = '1;
                    3:       v = VALUE_MAX;
                    4:       v = VALUE_MIN;
                    5:       v = table_radix;
                    default: v = table_radix - 1;
                endcase
            end
            1, 2:
                v = $urandom_range(0, 600) - 300;
            3, 4, 5:
            begin
                v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    // Zero, one, minus one, the radix, one below it and its negation, and both extremes.
    task automatic send_edge_values();
        send_number('0);
        send_number(1);
        send_number('1);
        send_number(table_radix - 1);
        send_number(table_radix);
        send_number(0 - table_radix);
        send_number(VALUE_MAX);
        send_number(VALUE_MIN);
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // Receiver back-pressure: stretches of stalls, mostly short, few long.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left  = stall_left - 1;
        end
        else if (!steady_flow && $urandom_range(0, 99) < 20)
        begin
            out_ready  <= 1'b0;
            stall_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    function automatic void note_error(string msg);
        if (error_count < 10)
            $display("%s", msg);
        error_count++;
    endfunction

    // Every accepted character beat is matched against the oldest owed one.
    always @(posedge clk)
    begin : check_output
        char_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                note_error($sformatf("unexpected beat: symbol %h last_symbol %b",
                                     symbol, last_symbol));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (symbol !== want.symbol || last_symbol !== want.last_symbol)
                    note_error($sformatf(
                        "beat mismatch: symbol exp %h got %h, last_symbol exp %b got %b",
                        want.symbol, symbol, want.last_symbol, last_symbol));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[radix_digit_emitter_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset leaves an all-zero table, so values must produce no characters.
    task automatic test_reset_table();
        send_number('0);
        send_number('1);
        send_number(VALUE_MIN);
    endtask

    // Every kind of broken table swallows its values silently.
    task automatic test_broken_tables();
        for (int f = FLAW_EMPTY; f <= FLAW_SATURATED; f++)
        begin
            build_table((f == FLAW_UNTERMINATED) ? POOL_SIZE : 10, f[0],
                        table_flaw_t'(f));
            load_table();
            send_number('0);
            send_number(random_number());
        end
    endtask

    // Smallest, decimal and largest radix with edge values. The first table
    // runs with no idling on either side.
    task automatic test_edge_values();
        steady_flow = 1'b1;
        build_table(2, 1'b0, FLAW_NONE);
        load_table();
        send_edge_values();
        steady_flow = 1'b0;
        build_table(10, 1'b0, FLAW_NONE);
        load_table();
        send_edge_values();
        build_table(POOL_SIZE, 1'b0, FLAW_NONE);
        load_table();
        send_edge_values();
    endtask

    // Random tables, mostly good, with bursts of random values. Every fourth
    // table the sender stops halfway until all owed characters are out.
    task automatic test_random_conversions();
        int          start;
        int          phase;
        int          radix;
        int          count;
        table_flaw_t flaw;
        start = valid_items_sent;
        phase = 0;
        while (valid_items_sent - start < RANDOM_ITEMS)
        begin
            steady_flow = ($urandom_range(0, 3) == 0);
            radix       = pick_radix();
            flaw        = FLAW_NONE;
            if ($urandom_range(0, 99) < 12)
            begin
                flaw = table_flaw_t'($urandom_range(FLAW_SINGLE, FLAW_UNTERMINATED));
                if (flaw == FLAW_UNTERMINATED)
                    radix = POOL_SIZE;
            end
            build_table(radix, 1'b1, flaw);
            load_table();
            count = (flaw == FLAW_NONE) ? $urandom_range(6, 30) : 3;
            for (int k = 0; k < count; k++)
            begin
                if (phase % 4 == 0 && k == count / 2)
                begin
                    release_input();
                    wait_for_results();
                end
                send_number(random_number());
            end
            phase++;
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        for (int r = 0; r < rde_pkg::NUM_REGS; r++)
            table_regs[r] = '0;
        evaluate_table();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_table();
        test_broken_tables();
        test_edge_values();
        test_random_conversions();

        release_input();
        settle();
        if (error_count == 0 && expected_chars.size() == 0)
            $display("[radix_digit_emitter_unit] OK");
        else
            $display("[radix_digit_emitter_unit] ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/rde_pkg.sv
rtl/rde_ram.sv
rtl/rde_tbl_check.sv
rtl/rde_divider.sv
rtl/radix_digit_emitter_unit.sv
tb/testbench.sv
